### design/pal_pkg.sv
`timescale 1ns / 1ps
// Package for the positional array list: field widths, operation and status codes,
// and the control word that the list control broadcasts to every storage cell.
// No dependencies.
package pal_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 7;
	localparam int LEN_W     = 7;
	localparam int FUNC_W    = 3;
	localparam int ST_W      = 2;
	localparam int CAP_W     = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT_AT    = 3'd0,
		FN_INSERT_FIRST = 3'd1,
		FN_INSERT_LAST  = 3'd2,
		FN_DELETE       = 3'd3,
		FN_READ         = 3'd4,
		FN_REPLACE      = 3'd5,
		FN_CLEAR        = 3'd6
	} func_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_INDEX = 2'd2
	} status_t;

	// What each cell does in the cycle an item is accepted.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_WRITE  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

### design/pal_req_if.sv
`timescale 1ns / 1ps
// Request channel of the positional array list: valid, ready and one operation item.
// Depends on pal_pkg.
interface pal_req_if import pal_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, func, position, value, input ready);
	modport sink (input valid, func, position, value, output ready);
endinterface

### design/pal_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the positional array list: valid, ready and one result item.
// Depends on pal_pkg.
interface pal_rsp_if import pal_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [ST_W-1:0]          status;
	logic [LEN_W-1:0]         length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink (input valid, read_value, status, length, output ready);
endinterface

### design/pal_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the positional array list: valid, ready and write data.
// Depends on pal_pkg.
interface pal_cfg_if import pal_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### design/pal_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
// Depends on pal_pkg.
module pal_cell import pal_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CMPW  = 7
) (
	input  logic                     clk,
	input  logic                     en,
	input  cell_ctl_t                ctl,
	input  logic [CMPW-1:0]          pos,
	input  logic signed [DATA_W-1:0] left,
	input  logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0] data,
	output logic signed [DATA_W-1:0] rd
);

	localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;
	logic                     at_pos;
	logic                     above_pos;

	assign at_pos    = (IDX == pos);
	assign above_pos = (IDX > pos);

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			OP_INSERT: begin
				if (above_pos) begin
					data_d = left;
				end else if (at_pos) begin
					data_d = ctl.value;
				end
			end
			OP_DELETE: begin
				if (above_pos || at_pos) begin
					data_d = right;
				end
			end
			OP_WRITE: begin
				if (at_pos) begin
					data_d = ctl.value;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_d;
		end
	end

	assign data = data_q;
	// Only the addressed cell drives the shared read bus; all others give zero.
	assign rd   = at_pos ? data_q : '0;

endmodule

### design/positional_array_list.sv
`timescale 1ns / 1ps
// Positional array list: an ordered list of up to DEPTH signed 32-bit entries in a chain of cells.
// Each accepted item's result is registered and offered in the cycle after it; one item is taken every cycle
// unless a pending result is stalled; the result register is freed in the same cycle it is taken.
// Reset (arst_n low, asynchronous) empties the list and sets the capacity limit to 64.
// Entry contents are not reset; an entry is only read after it has been written.
// Depends on pal_pkg, pal_req_if, pal_rsp_if, pal_cfg_if and pal_cell.
module positional_array_list import pal_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pal_req_if.sink    req,
	pal_rsp_if.source  rsp,
	pal_cfg_if.sink    cfg
);

	// Count needs to hold DEPTH itself. Comparisons run at a width that covers both the count
	// and the seven-bit position and limit fields.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

	logic [CAP_W-1:0]         cap_q;
	logic [CW-1:0]            count_q;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [ST_W-1:0]          status_q;
	logic [LEN_W-1:0]         length_q;

	logic                     accept;
	logic [CMPW-1:0]          cnt_ext;
	logic [CMPW-1:0]          pos_ext;
	logic [CMPW-1:0]          lim_ext;
	logic [CMPW-1:0]          cap_eff;
	logic                     full;
	logic [CMPW-1:0]          cnt_next;
	logic [CMPW-1:0]          cell_pos;
	cell_ctl_t                ctl;
	status_t                  status_d;
	logic                     take_read;
	logic signed [DATA_W-1:0] read_d;
	logic signed [DATA_W-1:0] rd_bus;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] cell_rd   [DEPTH];

	// The capacity register is always writable; the result stage frees up as soon as it is taken.
	assign cfg.ready = 1'b1;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	assign cnt_ext = CMPW'(count_q);
	assign pos_ext = CMPW'(req.position);
	assign lim_ext = CMPW'(cap_q);
	// A limit above the number of cells acts as the number of cells.
	assign cap_eff = (lim_ext > DEPTH_C) ? DEPTH_C : lim_ext;
	// A limit lowered below the current length keeps the entries but blocks every insert.
	assign full    = (cnt_ext >= cap_eff);

	// Decode the operation into a cell command, the new length and the status. On any error the
	// cells hold and the length stays the same.
	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.value = req.value;
		cell_pos  = pos_ext;
		cnt_next  = cnt_ext;
		status_d  = ST_OK;
		take_read = 1'b0;
		case (req.func)
			FN_INSERT_AT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					status_d = ST_INDEX;
				end else begin
					ctl.op   = OP_INSERT;
					cnt_next = cnt_ext + 1'b1;
				end
			end
			FN_INSERT_FIRST: begin
				cell_pos = '0;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.op   = OP_INSERT;
					cnt_next = cnt_ext + 1'b1;
				end
			end
			FN_INSERT_LAST: begin
				cell_pos = cnt_ext;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.op   = OP_INSERT;
					cnt_next = cnt_ext + 1'b1;
				end
			end
			FN_DELETE: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_INDEX;
				end else begin
					ctl.op    = OP_DELETE;
					take_read = 1'b1;
					cnt_next  = cnt_ext - 1'b1;
				end
			end
			FN_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_INDEX;
				end else begin
					take_read = 1'b1;
				end
			end
			FN_REPLACE: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_INDEX;
				end else begin
					ctl.op = OP_WRITE;
				end
			end
			FN_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				cnt_next = cnt_ext;
			end
		endcase
	end

	// The chain of cells. Each cell sees its left neighbor for an insert shift and its right
	// neighbor for a delete shift; the ends take zero and their own entry respectively.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pal_cell #(
			.INDEX (i),
			.CMPW  (CMPW)
		) u_cell (
			.clk   (clk),
			.en    (accept),
			.ctl   (ctl),
			.pos   (cell_pos),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	// Exactly one cell at most drives a nonzero value, so the read bus is a plain OR.
	always_comb begin
		rd_bus = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_bus = rd_bus | cell_rd[k];
		end
	end

	assign read_d = take_read ? rd_bus : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= CW'(cnt_next);
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_d;
			status_q     <= status_d;
			length_q     <= LEN_W'(cnt_next);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;

endmodule
